// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== design/lbc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the buffer cache.
package lbc_pkg;

	// Default directory size.
	localparam int NUM_ENTRIES_DEF = 16;

	// Field widths of the request and result beats.
	localparam int REQ_W    = 2;
	localparam int DEV_W    = 4;
	localparam int SEC_W    = 32;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 3;
	localparam int TAG_W    = DEV_W + SEC_W;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_GET     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd2;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		RES_HIT      = 3'd0,
		RES_MISS     = 3'd1,
		RES_BUSY     = 3'd2,
		RES_NOFREE   = 3'd3,
		RES_RELEASED = 3'd4,
		RES_RELERR   = 3'd5,
		RES_PRESENT  = 3'd6,
		RES_ABSENT   = 3'd7
	} res_code_t;

	// Source of the slot index in a result.
	typedef enum logic [1:0] {
		SLOT_ZERO,
		SLOT_BEST,
		SLOT_REL
	} slot_sel_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_MATCH,
		S_MATCH_WAIT,
		S_MATCH_DONE,
		S_VIC,
		S_VIC_WAIT,
		S_VIC_DONE,
		S_REL_DO
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load_req;
		logic      scan_clear;
		logic      scan_issue;
		logic      victim;
		logic      rel_sel;
		logic      grant_hit;
		logic      grant_miss;
		logic      do_release;
		logic      res_load;
		res_code_t res_code;
		slot_sel_t slot_sel;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             found;
		logic             best_busy;
		logic             rel_ok;
		logic             scan_last;
	} dp_stat_t;

endpackage

// ===== design/lbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lbc_ram #(
	parameter int WIDTH = lbc_pkg::TAG_W,
	parameter int DEPTH = lbc_pkg::NUM_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/lbc_ctrl.sv =====
// Controller state machine: sequences tag scans, victim scans, releases and result beats.
module lbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  lbc_pkg::dp_stat_t  stat,
	output lbc_pkg::dp_cmd_t   cmd
);

	lbc_pkg::state_t state_q;
	lbc_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	// The result register can take a new beat when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		cmd          = '0;
		cmd.res_code = lbc_pkg::RES_HIT;
		cmd.slot_sel = lbc_pkg::SLOT_ZERO;
		unique case (state_q)
			lbc_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = lbc_pkg::S_DISPATCH;
				end
			end
			lbc_pkg::S_DISPATCH: begin
				priority if (stat.req == lbc_pkg::REQ_GET || stat.req == lbc_pkg::REQ_CHECK) begin
					cmd.scan_clear = 1'b1;
					state_d        = lbc_pkg::S_MATCH;
				end else if (stat.req == lbc_pkg::REQ_RELEASE) begin
					cmd.rel_sel = 1'b1;
					state_d     = lbc_pkg::S_REL_DO;
				end else if (out_free) begin
					// Unknown request type.
					cmd.res_load = 1'b1;
					cmd.res_code = lbc_pkg::RES_RELERR;
					cmd.slot_sel = lbc_pkg::SLOT_ZERO;
					state_d      = lbc_pkg::S_IDLE;
				end else begin
					// Hold until the result register frees.
				end
			end
			lbc_pkg::S_MATCH: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_last) begin
					state_d = lbc_pkg::S_MATCH_WAIT;
				end
			end
			lbc_pkg::S_MATCH_WAIT: begin
				state_d = lbc_pkg::S_MATCH_DONE;
			end
			lbc_pkg::S_MATCH_DONE: begin
				priority if (stat.req == lbc_pkg::REQ_GET && !stat.found) begin
					cmd.scan_clear = 1'b1;
					state_d        = lbc_pkg::S_VIC;
				end else if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = lbc_pkg::S_IDLE;
					priority if (stat.req == lbc_pkg::REQ_CHECK) begin
						cmd.res_code = stat.found ? lbc_pkg::RES_PRESENT : lbc_pkg::RES_ABSENT;
						cmd.slot_sel = stat.found ? lbc_pkg::SLOT_BEST : lbc_pkg::SLOT_ZERO;
					end else if (stat.best_busy) begin
						cmd.res_code = lbc_pkg::RES_BUSY;
						cmd.slot_sel = lbc_pkg::SLOT_BEST;
					end else begin
						cmd.grant_hit = 1'b1;
						cmd.res_code  = lbc_pkg::RES_HIT;
						cmd.slot_sel  = lbc_pkg::SLOT_BEST;
					end
				end else begin
					// Hold until the result register frees.
				end
			end
			lbc_pkg::S_VIC: begin
				cmd.scan_issue = 1'b1;
				cmd.victim     = 1'b1;
				if (stat.scan_last) begin
					state_d = lbc_pkg::S_VIC_WAIT;
				end
			end
			lbc_pkg::S_VIC_WAIT: begin
				cmd.victim = 1'b1;
				state_d    = lbc_pkg::S_VIC_DONE;
			end
			lbc_pkg::S_VIC_DONE: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = lbc_pkg::S_IDLE;
					if (stat.found) begin
						cmd.grant_miss = 1'b1;
						cmd.res_code   = lbc_pkg::RES_MISS;
						cmd.slot_sel   = lbc_pkg::SLOT_BEST;
					end else begin
						cmd.res_code = lbc_pkg::RES_NOFREE;
						cmd.slot_sel = lbc_pkg::SLOT_ZERO;
					end
				end
			end
			lbc_pkg::S_REL_DO: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					cmd.slot_sel = lbc_pkg::SLOT_REL;
					state_d      = lbc_pkg::S_IDLE;
					if (stat.rel_ok) begin
						cmd.do_release = 1'b1;
						cmd.res_code   = lbc_pkg::RES_RELEASED;
					end else begin
						cmd.res_code = lbc_pkg::RES_RELERR;
					end
				end
			end
			default: begin
				state_d = lbc_pkg::S_IDLE;
			end
		endcase
	end

	// Result beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/lbc_dp.sv =====
// Datapath: tag RAM, busy/valid marks, recency ranks, serial compare and result register.
module lbc_dp #(
	parameter int NUM_ENTRIES = lbc_pkg::NUM_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lbc_pkg::REQ_W-1:0]     req_type,
	input  logic [lbc_pkg::DEV_W-1:0]     device_id,
	input  logic [lbc_pkg::SEC_W-1:0]     sector_num,
	input  logic [lbc_pkg::SLOT_W-1:0]    release_slot,
	input  lbc_pkg::dp_cmd_t              cmd,
	output lbc_pkg::dp_stat_t             stat,
	output logic [lbc_pkg::STATUS_W-1:0]  status,
	output logic [lbc_pkg::SLOT_W-1:0]    slot_index
);

	localparam int IW = $clog2(NUM_ENTRIES);

	// Request registers.
	logic [lbc_pkg::REQ_W-1:0]  req_q;
	logic [lbc_pkg::DEV_W-1:0]  dev_q;
	logic [lbc_pkg::SEC_W-1:0]  sec_q;
	logic [lbc_pkg::SLOT_W-1:0] rel_q;

	// Scan address and compare stage.
	logic [IW-1:0] idx_q;
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;

	// Best candidate found so far.
	logic          found_q;
	logic [IW-1:0] best_q;
	logic [IW-1:0] best_rank_q;
	logic          best_busy_q;

	// Per-entry marks and ranks.
	logic          busy_q  [NUM_ENTRIES];
	logic          valid_q [NUM_ENTRIES];
	logic [IW-1:0] rank_q  [NUM_ENTRIES];

	// Result register.
	logic [lbc_pkg::STATUS_W-1:0] status_q;
	logic [lbc_pkg::SLOT_W-1:0]   slot_q;

	logic [lbc_pkg::TAG_W-1:0] tag_rdata;
	logic [31:0]               rel_ext;
	logic [IW-1:0]             rel_idx;
	logic                      rel_in_range;
	logic                      rd_busy;
	logic                      rd_used;
	logic [IW-1:0]             rd_rank;
	logic                      match_hit;
	logic                      vic_hit;
	logic                      take;

	// Request capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= lbc_pkg::REQ_GET;
		end else if (cmd.load_req) begin
			req_q <= req_type;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			dev_q <= device_id;
			sec_q <= sector_num;
			rel_q <= release_slot;
		end
	end

	// Release index and range check.
	assign rel_ext      = 32'(rel_q);
	assign rel_idx      = rel_ext[IW-1:0];
	assign rel_in_range = rel_ext < 32'(NUM_ENTRIES);

	// Tag store, one entry read per scan cycle.
	lbc_ram #(
		.WIDTH (lbc_pkg::TAG_W),
		.DEPTH (NUM_ENTRIES)
	) u_tag_ram (
		.clk   (clk),
		.we    (cmd.grant_miss),
		.waddr (best_q),
		.wdata ({dev_q, sec_q}),
		.re    (cmd.scan_issue),
		.raddr (idx_q),
		.rdata (tag_rdata)
	);

	// Scan address counter and compare stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_issue;
			if (cmd.scan_clear) begin
				idx_q <= '0;
			end else if (cmd.scan_issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) begin
			cmp_idx_s1 <= idx_q;
		end else if (cmd.rel_sel) begin
			cmp_idx_s1 <= rel_idx;
		end
	end

	// Marks and rank of the entry in the compare stage.
	assign rd_busy = busy_q[cmp_idx_s1];
	assign rd_used = busy_q[cmp_idx_s1] | valid_q[cmp_idx_s1];
	assign rd_rank = rank_q[cmp_idx_s1];

	// Match wants the most recent used entry; victim wants the least recent free one.
	assign match_hit = rd_used && (tag_rdata == {dev_q, sec_q}) &&
		(!found_q || (rd_rank > best_rank_q));
	assign vic_hit   = !rd_busy && (!found_q || (rd_rank < best_rank_q));
	assign take      = cmp_vld_s1 && (cmd.victim ? vic_hit : match_hit);

	// Best candidate tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q      <= cmp_idx_s1;
			best_rank_q <= rd_rank;
			best_busy_q <= rd_busy;
		end
	end

	// Entry marks and recency ranks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				busy_q[i]  <= 1'b0;
				valid_q[i] <= 1'b0;
				rank_q[i]  <= IW'(i);
			end
		end else begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if ((cmd.grant_hit || cmd.grant_miss) && (best_q == IW'(i))) begin
					busy_q[i] <= 1'b1;
				end
				if (cmd.grant_miss && (best_q == IW'(i))) begin
					valid_q[i] <= 1'b1;
				end
				if (cmd.do_release) begin
					if (cmp_idx_s1 == IW'(i)) begin
						busy_q[i] <= 1'b0;
						rank_q[i] <= IW'(NUM_ENTRIES - 1);
					end else if (rank_q[i] > rd_rank) begin
						rank_q[i] <= rank_q[i] - 1'b1;
					end
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_code;
			unique case (cmd.slot_sel)
				lbc_pkg::SLOT_BEST: slot_q <= lbc_pkg::SLOT_W'(best_q);
				lbc_pkg::SLOT_REL:  slot_q <= rel_q;
				default:            slot_q <= '0;
			endcase
		end
	end

	// Status toward the controller.
	assign stat.req       = req_q;
	assign stat.found     = found_q;
	assign stat.best_busy = best_busy_q;
	assign stat.rel_ok    = rel_in_range && rd_busy;
	assign stat.scan_last = (idx_q == IW'(NUM_ENTRIES - 1));

	assign status     = status_q;
	assign slot_index = slot_q;

endmodule

// ===== design/lru_block_buffer_cache.sv =====
// One request is worked at a time.
// The tag RAM is read one entry per cycle, once for the match and again for the victim.
// A new request is taken the cycle after the result loads, even if that beat waits.
// Reset clears busy and valid marks and sets each entry's rank to its index;
// the tag RAM is not cleared and no clearing pass runs.
module lru_block_buffer_cache #(
	parameter int NUM_ENTRIES = lbc_pkg::NUM_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lbc_pkg::REQ_W-1:0]     req_type,
	input  logic [lbc_pkg::DEV_W-1:0]     device_id,
	input  logic [lbc_pkg::SEC_W-1:0]     sector_num,
	input  logic [lbc_pkg::SLOT_W-1:0]    release_slot,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lbc_pkg::STATUS_W-1:0]  status,
	output logic [lbc_pkg::SLOT_W-1:0]    slot_index
);

	lbc_pkg::dp_cmd_t  cmd;
	lbc_pkg::dp_stat_t stat;

	// Sequencer.
	lbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Directory storage and compare logic.
	lbc_dp #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_type     (req_type),
		.device_id    (device_id),
		.sector_num   (sector_num),
		.release_slot (release_slot),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.slot_index   (slot_index)
	);

endmodule

// ===== design/lbc_checker.sv =====
// Port-level checker for the buffer cache, bound to the top level.
`include "assert_macros.svh"

module lbc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [lbc_pkg::STATUS_W-1:0]  status,
	input logic [lbc_pkg::SLOT_W-1:0]    slot_index
);

	logic [1:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	// Requests accepted whose result beat has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			pending_q <= 2'(pending_q + 2'(in_beat) - 2'(out_beat));
		end
	end

	// A waiting result beat holds its payload.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(slot_index))
	// No result beat without an accepted request behind it.
	`ASSERT_IMPLY(a_no_orphan, clk, arst_n, out_valid, pending_q != 2'd0)
	// At most one request in work and one result waiting.
	`ASSERT_IMPLY(a_pending_bound, clk, arst_n, 1'b1, pending_q != 2'd3)
	// After an accepted request the input side stalls while it is worked.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_beat, in_stall)

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (.*);
